[hdl/elx_pkg.sv]
// ----------------------------------------------------------------------------
// elx_pkg: shared types and helpers for the expression lexer
// Token kinds, scan modes, keyword matcher codes and byte classes.
// ----------------------------------------------------------------------------
package elx_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int LINE_BITS_DEF   = 16;
  localparam int TOK_SLOTS       = 3;   // most tokens one byte can finish

  typedef enum logic [3:0] {
    K_EOF     = 4'd0,
    K_ERROR   = 4'd1,
    K_IDENT   = 4'd2,
    K_INT     = 4'd3,
    K_DEC     = 4'd4,
    K_TRUE    = 4'd5,
    K_FALSE   = 4'd6,
    K_PLUS    = 4'd7,
    K_MINUS   = 4'd8,
    K_STAR    = 4'd9,
    K_SLASH   = 4'd10,
    K_EQUALS  = 4'd11,
    K_COMMA   = 4'd12,
    K_LPAREN  = 4'd13,
    K_RPAREN  = 4'd14,
    K_NEWLINE = 4'd15
  } kind_t;

  typedef enum logic [7:0] {
    M_IDLE    = 8'b0000_0001,
    M_IDENT   = 8'b0000_0010,
    M_INT     = 8'b0000_0100,
    M_INT_DOT = 8'b0000_1000,
    M_DOT     = 8'b0001_0000,
    M_FRAC    = 8'b0010_0000,
    M_SLASH   = 8'b0100_0000,
    M_COMMENT = 8'b1000_0000
  } mode_t;

  // keyword prefix tracker: how much of "true" / "false" has been seen
  typedef enum logic [9:0] {
    KW_NONE  = 10'b00_0000_0001,
    KW_T     = 10'b00_0000_0010,
    KW_TR    = 10'b00_0000_0100,
    KW_TRU   = 10'b00_0000_1000,
    KW_TRUE  = 10'b00_0001_0000,
    KW_F     = 10'b00_0010_0000,
    KW_FA    = 10'b00_0100_0000,
    KW_FAL   = 10'b00_1000_0000,
    KW_FALS  = 10'b01_0000_0000,
    KW_FALSE = 10'b10_0000_0000
  } kw_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic kw_t kw_first(input logic [7:0] c);
    if (c == "t") return KW_T;
    if (c == "f") return KW_F;
    return KW_NONE;
  endfunction

  function automatic kw_t kw_step(input kw_t k, input logic [7:0] c);
    case (k)
      KW_T:    return (c == "r") ? KW_TR    : KW_NONE;
      KW_TR:   return (c == "u") ? KW_TRU   : KW_NONE;
      KW_TRU:  return (c == "e") ? KW_TRUE  : KW_NONE;
      KW_F:    return (c == "a") ? KW_FA    : KW_NONE;
      KW_FA:   return (c == "l") ? KW_FAL   : KW_NONE;
      KW_FAL:  return (c == "s") ? KW_FALS  : KW_NONE;
      KW_FALS: return (c == "e") ? KW_FALSE : KW_NONE;
      default: return KW_NONE;
    endcase
  endfunction

endpackage

[hdl/elx_scan.sv]
// ----------------------------------------------------------------------------
// elx_scan: lexer state and per-byte token generation
// Scan mode, offsets and line count; one byte in, up to three tokens out.
// ----------------------------------------------------------------------------
module elx_scan #(
  parameter int OW = elx_pkg::OFFSET_BITS_DEF,
  parameter int LW = elx_pkg::LINE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           ch,
  output logic [1:0]           tok_cnt,
  output elx_pkg::kind_t       tok_kind  [elx_pkg::TOK_SLOTS],
  output logic [OW-1:0]        tok_start [elx_pkg::TOK_SLOTS],
  output logic [OW-1:0]        tok_len   [elx_pkg::TOK_SLOTS],
  output logic [LW-1:0]        tok_line
);
  import elx_pkg::*;

  localparam logic [OW-1:0] OFF_MAX  = '1;
  localparam logic [LW-1:0] LINE_MAX = '1;

  mode_t         mode, mode_next;
  kw_t           kw, kw_next;
  logic [OW-1:0] byte_offset, byte_offset_next;
  logic [LW-1:0] current_line, current_line_next;
  logic [OW-1:0] token_start, token_start_next;
  logic [OW-1:0] token_len, token_len_next;

  function automatic logic [OW-1:0] sat_inc(input logic [OW-1:0] v);
    return (v == OFF_MAX) ? v : v + 1'b1;
  endfunction

  always_comb begin
    logic        rescan;
    logic        eof;
    logic [1:0]  n;
    logic [OW:0] err_sum;
    mode_next         = mode;
    kw_next           = kw;
    byte_offset_next  = byte_offset;
    current_line_next = current_line;
    token_start_next  = token_start;
    token_len_next    = token_len;
    rescan            = 1'b1;
    eof               = 1'b0;
    n                 = 2'd0;
    err_sum           = {1'b0, token_start} + {1'b0, token_len} - 1'b1;
    for (int i = 0; i < TOK_SLOTS; i++) begin
      tok_kind[i]  = K_EOF;
      tok_start[i] = '0;
      tok_len[i]   = '0;
    end

    // finish or extend the pending token
    case (mode)
      M_IDENT: begin
        if (is_letter(ch) || is_numeral(ch) || ch == CH_UNDER) begin
          token_len_next = sat_inc(token_len);
          kw_next        = kw_step(kw, ch);
          rescan         = 1'b0;
        end else begin
          tok_kind[n]  = (kw == KW_TRUE) ? K_TRUE : (kw == KW_FALSE) ? K_FALSE : K_IDENT;
          tok_start[n] = token_start;
          tok_len[n]   = token_len;
          n            = n + 2'd1;
        end
      end
      M_INT: begin
        if (is_numeral(ch)) begin
          token_len_next = sat_inc(token_len);
          rescan         = 1'b0;
        end else if (ch == CH_DOT) begin
          token_len_next = sat_inc(token_len);
          mode_next      = M_INT_DOT;
          rescan         = 1'b0;
        end else begin
          tok_kind[n]  = K_INT;
          tok_start[n] = token_start;
          tok_len[n]   = token_len;
          n            = n + 2'd1;
        end
      end
      M_INT_DOT: begin
        if (is_numeral(ch)) begin
          token_len_next = sat_inc(token_len);
          mode_next      = M_FRAC;
          rescan         = 1'b0;
        end else begin
          // trailing dot splits off as an error token
          tok_kind[n]  = K_INT;
          tok_start[n] = token_start;
          tok_len[n]   = token_len - 1'b1;
          n            = n + 2'd1;
          tok_kind[n]  = K_ERROR;
          tok_start[n] = (err_sum > {1'b0, OFF_MAX}) ? OFF_MAX : err_sum[OW-1:0];
          tok_len[n]   = OW'(1);
          n            = n + 2'd1;
        end
      end
      M_DOT: begin
        if (is_numeral(ch)) begin
          token_len_next = sat_inc(token_len);
          mode_next      = M_FRAC;
          rescan         = 1'b0;
        end else begin
          tok_kind[n]  = K_ERROR;
          tok_start[n] = token_start;
          tok_len[n]   = OW'(1);
          n            = n + 2'd1;
        end
      end
      M_FRAC: begin
        if (is_numeral(ch)) begin
          token_len_next = sat_inc(token_len);
          rescan         = 1'b0;
        end else begin
          tok_kind[n]  = K_DEC;
          tok_start[n] = token_start;
          tok_len[n]   = token_len;
          n            = n + 2'd1;
        end
      end
      M_SLASH: begin
        if (ch == CH_SLASH) begin
          mode_next = M_COMMENT;
          rescan    = 1'b0;
        end else begin
          tok_kind[n]  = K_SLASH;
          tok_start[n] = token_start;
          tok_len[n]   = OW'(1);
          n            = n + 2'd1;
        end
      end
      M_COMMENT: begin
        if (ch != CH_LF && ch != CH_NUL) rescan = 1'b0;
      end
      default: ;
    endcase

    // scan the byte from the between-tokens state
    if (rescan) begin
      mode_next = M_IDLE;
      kw_next   = KW_NONE;
      case (ch)
        CH_NUL: begin
          tok_kind[n]  = K_EOF;
          tok_start[n] = byte_offset;
          tok_len[n]   = '0;
          n            = n + 2'd1;
          eof          = 1'b1;
        end
        CH_SPACE, CH_TAB, CH_CR: ;
        CH_LF: begin
          tok_kind[n]  = K_NEWLINE;
          tok_start[n] = byte_offset;
          tok_len[n]   = OW'(1);
          n            = n + 2'd1;
          if (current_line != LINE_MAX) current_line_next = current_line + 1'b1;
        end
        CH_SLASH, CH_DOT: begin
          mode_next        = (ch == CH_SLASH) ? M_SLASH : M_DOT;
          token_start_next = byte_offset;
          token_len_next   = OW'(1);
        end
        CH_LPAREN, CH_RPAREN, CH_PLUS, CH_MINUS, CH_STAR, CH_EQUALS, CH_COMMA: begin
          case (ch)
            CH_LPAREN: tok_kind[n] = K_LPAREN;
            CH_RPAREN: tok_kind[n] = K_RPAREN;
            CH_PLUS:   tok_kind[n] = K_PLUS;
            CH_MINUS:  tok_kind[n] = K_MINUS;
            CH_STAR:   tok_kind[n] = K_STAR;
            CH_EQUALS: tok_kind[n] = K_EQUALS;
            default:   tok_kind[n] = K_COMMA;
          endcase
          tok_start[n] = byte_offset;
          tok_len[n]   = OW'(1);
          n            = n + 2'd1;
        end
        default: begin
          if (is_letter(ch)) begin
            mode_next        = M_IDENT;
            kw_next          = kw_first(ch);
            token_start_next = byte_offset;
            token_len_next   = OW'(1);
          end else if (is_numeral(ch)) begin
            mode_next        = M_INT;
            token_start_next = byte_offset;
            token_len_next   = OW'(1);
          end else begin
            tok_kind[n]  = K_ERROR;
            tok_start[n] = byte_offset;
            tok_len[n]   = OW'(1);
            n            = n + 2'd1;
          end
        end
      endcase
    end

    if (eof) begin
      mode_next         = M_IDLE;
      kw_next           = KW_NONE;
      byte_offset_next  = '0;
      current_line_next = LW'(1);
      token_start_next  = '0;
      token_len_next    = '0;
    end else begin
      byte_offset_next = sat_inc(byte_offset);
    end

    tok_cnt = n;
  end

  // every token of a byte starts on the line current at that byte
  assign tok_line = current_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      kw           <= KW_NONE;
      byte_offset  <= '0;
      current_line <= LW'(1);
      token_start  <= '0;
      token_len    <= '0;
    end else if (step) begin
      mode         <= mode_next;
      kw           <= kw_next;
      byte_offset  <= byte_offset_next;
      current_line <= current_line_next;
      token_start  <= token_start_next;
      token_len    <= token_len_next;
    end
  end

  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    (step && ch == CH_NUL) |=> (byte_offset == '0 && current_line == LW'(1) && mode == M_IDLE))
    else $error("lexer state not restarted after end of text");

  a_comment_quiet: assert property (@(posedge clk) disable iff (rst)
    (step && mode == M_COMMENT && ch != CH_LF && ch != CH_NUL) |-> tok_cnt == 2'd0)
    else $error("token produced inside a comment");

endmodule

[hdl/elx_queue.sv]
// ----------------------------------------------------------------------------
// elx_queue: token output buffer
// Holds the tokens of one byte and presents them one transfer at a time.
// ----------------------------------------------------------------------------
module elx_queue #(
  parameter int OW = elx_pkg::OFFSET_BITS_DEF,
  parameter int LW = elx_pkg::LINE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [1:0]           tok_cnt,
  input  elx_pkg::kind_t       tok_kind  [elx_pkg::TOK_SLOTS],
  input  logic [OW-1:0]        tok_start [elx_pkg::TOK_SLOTS],
  input  logic [OW-1:0]        tok_len   [elx_pkg::TOK_SLOTS],
  input  logic [LW-1:0]        tok_line,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           kind,
  output logic [OW-1:0]        start_offset,
  output logic [OW-1:0]        token_length,
  output logic [LW-1:0]        line_number,
  output logic                 last_of_run
);
  import elx_pkg::*;

  kind_t         slot_kind  [TOK_SLOTS];
  logic [OW-1:0] slot_start [TOK_SLOTS];
  logic [OW-1:0] slot_len   [TOK_SLOTS];
  logic [LW-1:0] slot_line;
  logic [1:0]    rem;
  logic          pop;

  assign out_valid    = (rem != 2'd0);
  assign pop          = out_valid && !out_stall;
  // room for a new batch once the last pending token leaves
  assign free         = (rem == 2'd0) || (rem == 2'd1 && pop);
  assign kind         = slot_kind[0];
  assign start_offset = slot_start[0];
  assign token_length = slot_len[0];
  assign line_number  = slot_line;
  assign last_of_run  = (rem == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (load) begin
      rem <= tok_cnt;
    end else if (pop) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_line <= tok_line;
      for (int i = 0; i < TOK_SLOTS; i++) begin
        slot_kind[i]  <= tok_kind[i];
        slot_start[i] <= tok_start[i];
        slot_len[i]   <= tok_len[i];
      end
    end else if (pop) begin
      for (int i = 0; i < TOK_SLOTS - 1; i++) begin
        slot_kind[i]  <= slot_kind[i+1];
        slot_start[i] <= slot_start[i+1];
        slot_len[i]   <= slot_len[i+1];
      end
    end
  end

  a_hold_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> rem == $past(rem))
    else $error("pending token count changed while output stalled");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> rem == $past(tok_cnt))
    else $error("batch count not captured on load");

endmodule

[hdl/expression_language_lexer_unit.sv]
// A byte in the input holding register is scanned; its tokens are registered in
// the output buffer and offered from there. Throughput: one byte per cycle while
// out_stall is low and each byte yields at most one token; a byte that finishes
// n tokens holds the single output register for n transfers.
// Reset (rst, synchronous): empty buffers, idle scan mode, offset 0, line 1.
// ----------------------------------------------------------------------------
// expression_language_lexer_unit: streaming lexer top level
// Input holding register, scanner and token output buffer.
// ----------------------------------------------------------------------------
module expression_language_lexer_unit #(
  parameter int OFFSET_BITS = elx_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = elx_pkg::LINE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             ch,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [3:0]             kind,
  output logic [OFFSET_BITS-1:0] start_offset,
  output logic [OFFSET_BITS-1:0] token_length,
  output logic [LINE_BITS-1:0]   line_number,
  output logic                   last_of_run
);
  import elx_pkg::*;

  logic                   hold_valid;
  logic [7:0]             hold_ch;
  logic                   free;
  logic                   step;
  logic [1:0]             tok_cnt;
  kind_t                  tok_kind  [TOK_SLOTS];
  logic [OFFSET_BITS-1:0] tok_start [TOK_SLOTS];
  logic [OFFSET_BITS-1:0] tok_len   [TOK_SLOTS];
  logic [LINE_BITS-1:0]   tok_line;

  assign step     = hold_valid && free;
  assign in_stall = hold_valid && !free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (step) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) hold_ch <= ch;
  end

  elx_scan #(
    .OW(OFFSET_BITS),
    .LW(LINE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .ch        (hold_ch),
    .tok_cnt   (tok_cnt),
    .tok_kind  (tok_kind),
    .tok_start (tok_start),
    .tok_len   (tok_len),
    .tok_line  (tok_line)
  );

  elx_queue #(
    .OW(OFFSET_BITS),
    .LW(LINE_BITS)
  ) u_queue (
    .clk          (clk),
    .rst          (rst),
    .load         (step),
    .tok_cnt      (tok_cnt),
    .tok_kind     (tok_kind),
    .tok_start    (tok_start),
    .tok_len      (tok_len),
    .tok_line     (tok_line),
    .free         (free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .start_offset (start_offset),
    .token_length (token_length),
    .line_number  (line_number),
    .last_of_run  (last_of_run)
  );

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the expression lexer
// Feeds source bytes over the valid/stall input, predicts every token in a
// local scanner model and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import elx_pkg::*;

  localparam int OW          = OFFSET_BITS_DEF;
  localparam int LW          = LINE_BITS_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct {
    kind_t          kind;
    logic [OW-1:0]  off;
    logic [OW-1:0]  len;
    logic [LW-1:0]  row;
    logic           last;
  } token_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic [7:0]     ch = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [3:0]     kind;
  logic [OW-1:0]  start_offset;
  logic [OW-1:0]  token_length;
  logic [LW-1:0]  line_number;
  logic           last_of_run;

  expression_language_lexer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ch           (ch),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .start_offset (start_offset),
    .token_length (token_length),
    .line_number  (line_number),
    .last_of_run  (last_of_run)
  );

  always #10 clk = ~clk;

  // scanner state mirrored from the block
  mode_t          scan_st  = M_IDLE;
  kw_t            kw_st    = KW_NONE;
  logic [OW-1:0]  pos      = '0;
  logic [LW-1:0]  row_no   = LW'(1);
  logic [OW-1:0]  tok_start = '0;
  logic [OW-1:0]  tok_len  = '0;

  token_t         expected_tokens[$];
  int             step_tokens;
  int             idle_pct = 0;
  int             stall_pct = 0;
  int             mismatch_count = 0;
  int             bytes_sent = 0;
  int             busy_bytes = 0;
  int             tokens_checked = 0;
  int             cycle_count = 0;

  function automatic logic [OW-1:0] clamp_off(input logic [OW:0] v);
    return v[OW] ? {OW{1'b1}} : v[OW-1:0];
  endfunction

  function automatic logic alpha_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic kw_t kw_advance(input kw_t k, input logic [7:0] c);
    kw_t nxt;
    nxt = KW_NONE;
    if (k == KW_T && c == "r") nxt = KW_TR;
    if (k == KW_TR && c == "u") nxt = KW_TRU;
    if (k == KW_TRU && c == "e") nxt = KW_TRUE;
    if (k == KW_F && c == "a") nxt = KW_FA;
    if (k == KW_FA && c == "l") nxt = KW_FAL;
    if (k == KW_FAL && c == "s") nxt = KW_FALS;
    if (k == KW_FALS && c == "e") nxt = KW_FALSE;
    return nxt;
  endfunction

  function automatic void push_token(input kind_t k, input logic [OW-1:0] off,
                                     input logic [OW-1:0] len);
    token_t t;
    t.kind = k;
    t.off  = off;
    t.len  = len;
    t.row  = row_no;
    t.last = 1'b0;
    expected_tokens.push_back(t);
    step_tokens++;
  endfunction

  function automatic void open_lexeme(input mode_t m);
    scan_st   = m;
    tok_start = pos;
    tok_len   = OW'(1);
  endfunction

  // byte seen between tokens; returns 1 at end of text
  function automatic logic scan_fresh(input logic [7:0] c);
    case (c)
      CH_NUL: begin
        push_token(K_EOF, pos, '0);
        return 1'b1;
      end
      CH_SPACE, CH_TAB, CH_CR: ;
      CH_LF: begin
        push_token(K_NEWLINE, pos, OW'(1));
        if (row_no != {LW{1'b1}}) row_no = row_no + 1'b1;
      end
      CH_SLASH:  open_lexeme(M_SLASH);
      CH_DOT:    open_lexeme(M_DOT);
      CH_LPAREN: push_token(K_LPAREN, pos, OW'(1));
      CH_RPAREN: push_token(K_RPAREN, pos, OW'(1));
      CH_PLUS:   push_token(K_PLUS, pos, OW'(1));
      CH_MINUS:  push_token(K_MINUS, pos, OW'(1));
      CH_STAR:   push_token(K_STAR, pos, OW'(1));
      CH_EQUALS: push_token(K_EQUALS, pos, OW'(1));
      CH_COMMA:  push_token(K_COMMA, pos, OW'(1));
      default: begin
        if (alpha_byte(c)) begin
          open_lexeme(M_IDENT);
          kw_st = (c == "t") ? KW_T : (c == "f") ? KW_F : KW_NONE;
        end else if (digit_byte(c)) begin
          open_lexeme(M_INT);
        end else begin
          push_token(K_ERROR, pos, OW'(1));
        end
      end
    endcase
    return 1'b0;
  endfunction

  // expected tokens for one accepted byte
  function automatic void lex_byte(input logic [7:0] c);
    logic rescan;
    logic done;
    step_tokens = 0;
    rescan = 1'b1;
    done = 1'b0;
    case (scan_st)
      M_IDENT: begin
        if (alpha_byte(c) || digit_byte(c) || c == CH_UNDER) begin
          tok_len = clamp_off({1'b0, tok_len} + 1'b1);
          kw_st = kw_advance(kw_st, c);
          rescan = 1'b0;
        end else begin
          push_token(kw_st == KW_TRUE ? K_TRUE : kw_st == KW_FALSE ? K_FALSE : K_IDENT,
                     tok_start, tok_len);
        end
      end
      M_INT: begin
        if (digit_byte(c) || c == CH_DOT) begin
          tok_len = clamp_off({1'b0, tok_len} + 1'b1);
          if (c == CH_DOT) scan_st = M_INT_DOT;
          rescan = 1'b0;
        end else begin
          push_token(K_INT, tok_start, tok_len);
        end
      end
      M_INT_DOT, M_DOT: begin
        if (digit_byte(c)) begin
          tok_len = clamp_off({1'b0, tok_len} + 1'b1);
          scan_st = M_FRAC;
          rescan = 1'b0;
        end else if (scan_st == M_INT_DOT) begin
          // integer without its dot, then the dot alone as an error
          push_token(K_INT, tok_start, tok_len - 1'b1);
          push_token(K_ERROR, clamp_off({1'b0, tok_start} + {1'b0, tok_len} - 1'b1),
                     OW'(1));
        end else begin
          push_token(K_ERROR, tok_start, OW'(1));
        end
      end
      M_FRAC: begin
        if (digit_byte(c)) begin
          tok_len = clamp_off({1'b0, tok_len} + 1'b1);
          rescan = 1'b0;
        end else begin
          push_token(K_DEC, tok_start, tok_len);
        end
      end
      M_SLASH: begin
        if (c == CH_SLASH) begin
          scan_st = M_COMMENT;
          rescan = 1'b0;
        end else begin
          push_token(K_SLASH, tok_start, OW'(1));
        end
      end
      M_COMMENT: rescan = (c == CH_LF || c == CH_NUL);
      default: ;
    endcase
    if (rescan) begin
      scan_st = M_IDLE;
      kw_st = KW_NONE;
      done = scan_fresh(c);
    end
    if (done) begin
      scan_st = M_IDLE;
      kw_st = KW_NONE;
      pos = '0;
      row_no = LW'(1);
      tok_start = '0;
      tok_len = '0;
    end else begin
      pos = clamp_off({1'b0, pos} + 1'b1);
    end
    if (step_tokens > 0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  // ---- driving ----

  task automatic send_byte(input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (scan_st != M_COMMENT && c != CH_SPACE && c != CH_TAB && c != CH_CR) busy_bytes++;
    lex_byte(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // ---- checking ----

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    token_t t;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        mismatch_count++;
        $error("token transfer with nothing expected: kind %0d offset %0d",
               kind, start_offset);
      end else begin
        t = expected_tokens.pop_front();
        tokens_checked++;
        check_field("kind", 32'(t.kind), 32'(kind));
        check_field("start_offset", 32'(t.off), 32'(start_offset));
        check_field("token_length", 32'(t.len), 32'(token_length));
        check_field("line_number", 32'(t.row), 32'(line_number));
        check_field("last_of_run", 32'(t.last), 32'(last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d tokens outstanding",
               cycle_count, expected_tokens.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---- tests ----

  task automatic test_all_tokens();
    send_text("(ab+C9)*x_1-2/y=3,true false\n");
    send_byte(CH_NUL);
  endtask

  task automatic test_special_cases();
    // int then dot then no digit, lone dot, slash alone, comment, bad bytes
    send_text("1.+.x .5 2.75/z//c\n#");
    send_byte(CH_TAB);
    send_byte(CH_CR);
    send_text("tru");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(CH_NUL);
    send_text("//q");
    send_byte(CH_NUL);     // zero ends the comment and the text
    send_text("7");
    send_byte(CH_NUL);     // pending number flushed before eof
    send_byte(CH_NUL);     // empty text
  endtask

  task automatic send_fragment();
    int r;
    int n;
    string punct;
    punct = "+-*=,()";
    r = $urandom_range(99);
    if (r < 22) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(4))
          0: send_text("true");
          1: send_text("false");
          2: send_text("tru");
          3: send_text("falsey");
          default: send_text("t_1");
        endcase
      end else begin
        send_byte(8'($urandom_range(25)) + ($urandom_range(1) ? "a" : "A"));
        n = $urandom_range(5);
        repeat (n) begin
          r = $urandom_range(62);
          send_byte(8'(r < 26 ? "a" + r : r < 52 ? "A" + r - 26 :
                       r < 62 ? "0" + r - 52 : CH_UNDER));
        end
      end
    end else if (r < 34) begin
      repeat ($urandom_range(1, 5)) send_byte(8'("0" + $urandom_range(9)));
    end else if (r < 42) begin
      if ($urandom_range(1)) send_byte(8'("0" + $urandom_range(9)));
      send_byte(CH_DOT);
      repeat ($urandom_range(1, 3)) send_byte(8'("0" + $urandom_range(9)));
    end else if (r < 46) begin
      repeat ($urandom_range(1, 3)) send_byte(8'("0" + $urandom_range(9)));
      send_byte(CH_DOT);
      send_byte(punct[$urandom_range(6)]);
    end else if (r < 49) begin
      send_byte(CH_DOT);
    end else if (r < 64) begin
      send_byte(punct[$urandom_range(6)]);
    end else if (r < 72) begin
      case ($urandom_range(2))
        0: send_byte(CH_SPACE);
        1: send_byte(CH_TAB);
        default: send_byte(CH_CR);
      endcase
    end else if (r < 78) begin
      send_byte(CH_LF);
    end else if (r < 84) begin
      send_text("//");
      repeat ($urandom_range(4)) send_byte(8'($urandom_range(32, 126)));
      send_byte($urandom_range(4) == 0 ? CH_NUL : CH_LF);
    end else if (r < 87) begin
      send_byte(CH_SLASH);
    end else if (r < 96) begin
      send_byte(8'($urandom_range(1, 255)));
    end else begin
      send_byte(CH_NUL);
    end
  endtask

  task automatic test_random_traffic(input int gap_pct, input int hold_pct,
                                     input int n_items);
    int stop_at;
    idle_pct  = gap_pct;
    stall_pct = hold_pct;
    stop_at   = busy_bytes + n_items;
    while (busy_bytes < stop_at) send_fragment();
    send_byte(CH_NUL);
    wait_drain();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_all_tokens();
    test_special_cases();
    wait_drain();
    test_random_traffic(0, 0, 9);
    test_random_traffic(74, 0, 9);
    test_random_traffic(0, 74, 9);
    test_random_traffic(6, 6, 9);
    idle_pct  = 0;
    stall_pct = 0;

    $display("Sent %0d bytes (%0d outside blanks and comments), checked %0d tokens",
             bytes_sent, busy_bytes, tokens_checked);
    $display("Covered every token kind, split numbers, comments, bad bytes and four "
             , "handshake mixes");
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/elx_pkg.sv
hdl/elx_scan.sv
hdl/elx_queue.sv
hdl/expression_language_lexer_unit.sv
test/tb_top.sv
